// ===== design/aolq_pkg.sv =====
// Shared constants for the open-list queue unit.
// Holds request and status codes and the cost widths. Depends on nothing.
package aolq_pkg;
  localparam logic REQ_OFFER = 1'b0;
  localparam logic REQ_POP   = 1'b1;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_LOWERED  = 3'd1;
  localparam logic [2:0] ST_KEPT     = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_POPPED   = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  localparam int COST_W = 24;
  localparam int SUM_W  = 25;
endpackage

// ===== design/aolq_store.sv =====
// Entry store of the open-list queue unit.
// Single-port write, single-port read synchronous memory with a registered read port.
// Uses no package.
module aolq_store #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 80
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ===== design/astar_open_list_queue_unit.sv =====
// Open-list priority queue with decrease-key; entries live in aolq_store.
// Every request is served by a linear scan of the store: SCAN, then DECIDE, then for a
// pop of a non-empty queue POPRD and POPWR, then DONE, which registers the result.
// One transaction at a time: the next is accepted in the cycle after the result is
// registered, and a stalled result holds the following one in its last step.
// Reset (synchronous, rst_n low) empties the queue; store contents stay undefined.
module astar_open_list_queue_unit #(
  parameter int CAPACITY  = 256,
  parameter int NODE_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_req_type,
  input  logic [15:0]                    in_node_id,
  input  logic [23:0]                    in_path_cost,
  input  logic [23:0]                    in_estimate,
  input  logic [15:0]                    in_from_node,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_status,
  output logic [15:0]                    out_node,
  output logic [23:0]                    out_cost,
  output logic [23:0]                    out_estimate,
  output logic [15:0]                    out_from,
  output logic [$clog2(CAPACITY+1)-1:0]  out_occupancy
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int CB = aolq_pkg::COST_W;
  localparam int EW = 2 * NODE_BITS + 2 * CB;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_POPRD  = 3'd3;
  localparam logic [2:0] S_POPWR  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]           state_r;
  logic                 req_r;
  logic [NODE_BITS-1:0] node_r, from_r;
  logic [CB-1:0]        cost_r, est_r;
  logic [CW-1:0]        count_r, idx_r;
  logic                 rd_vld_r;
  logic [AW-1:0]        rd_idx_r;
  logic                 hit_r;
  logic [AW-1:0]        hit_idx_r;
  logic [CB-1:0]        hit_cost_r, hit_est_r;
  logic [AW-1:0]        best_idx_r;
  logic [aolq_pkg::SUM_W-1:0] best_f_r;
  logic [EW-1:0]        best_ent_r;
  logic [2:0]           stat_r;
  logic                 out_valid_r;
  logic [2:0]           out_status_r;
  logic [15:0]          out_node_r, out_from_r;
  logic [CB-1:0]        out_cost_r, out_est_r;
  logic [CW-1:0]        out_occ_r;

  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [EW-1:0]        rd_data, wr_data;
  logic [NODE_BITS-1:0] e_node, e_from, b_node, b_from;
  logic [CB-1:0]        e_cost, e_est, b_cost, b_est;
  logic [aolq_pkg::SUM_W-1:0] e_f;
  logic [31:0]          in_node32, in_from32, b_node32, b_from32;
  logic                 scan_more, room;
  logic [CW-1:0]        last_idx;

  assign in_node32 = 32'(in_node_id);
  assign in_from32 = 32'(in_from_node);
  assign {e_node, e_cost, e_est, e_from} = rd_data;
  assign {b_node, b_cost, b_est, b_from} = best_ent_r;
  assign b_node32 = 32'(b_node);
  assign b_from32 = 32'(b_from);
  assign e_f = {1'b0, e_cost} + {1'b0, e_est};
  assign scan_more = idx_r < count_r;
  assign room = count_r < CW'(CAPACITY);
  assign last_idx = count_r - CW'(1);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_r[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = hit_idx_r;
    wr_data = {node_r, cost_r, hit_est_r, from_r};
    if (state_r == S_SCAN && scan_more) begin
      rd_en = 1'b1;
    end
    if (state_r == S_POPRD) begin
      rd_en   = 1'b1;
      rd_addr = last_idx[AW-1:0];
    end
    if (state_r == S_DECIDE && req_r == aolq_pkg::REQ_OFFER) begin
      if (hit_r) begin
        wr_en = cost_r < hit_cost_r;
      end else if (room) begin
        wr_en   = 1'b1;
        wr_addr = count_r[AW-1:0];
        wr_data = {node_r, cost_r, est_r, from_r};
      end
    end
    if (state_r == S_POPWR) begin
      wr_en   = 1'b1;
      wr_addr = best_idx_r;
      wr_data = rd_data;
    end
  end

  aolq_store #(.DEPTH(CAPACITY), .WIDTH(EW)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      rd_vld_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r   <= in_req_type;
            node_r  <= in_node32[NODE_BITS-1:0];
            from_r  <= in_from32[NODE_BITS-1:0];
            cost_r  <= in_path_cost;
            est_r   <= in_estimate;
            idx_r   <= '0;
            hit_r   <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_more) begin
            idx_r    <= idx_r + CW'(1);
            rd_vld_r <= 1'b1;
            rd_idx_r <= idx_r[AW-1:0];
          end
          if (rd_vld_r) begin
            if (req_r == aolq_pkg::REQ_OFFER) begin
              if (e_node == node_r) begin
                hit_r      <= 1'b1;
                hit_idx_r  <= rd_idx_r;
                hit_cost_r <= e_cost;
                hit_est_r  <= e_est;
              end
            end else if (rd_idx_r == '0 || e_f < best_f_r ||
                         (e_f == best_f_r && e_node < b_node)) begin
              best_idx_r <= rd_idx_r;
              best_f_r   <= e_f;
              best_ent_r <= rd_data;
            end
          end
          if (!scan_more && !rd_vld_r) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_r <= S_DONE;
          if (req_r == aolq_pkg::REQ_OFFER) begin
            if (hit_r) begin
              stat_r <= (cost_r < hit_cost_r) ? aolq_pkg::ST_LOWERED : aolq_pkg::ST_KEPT;
            end else if (room) begin
              stat_r  <= aolq_pkg::ST_INSERTED;
              count_r <= count_r + CW'(1);
            end else begin
              stat_r <= aolq_pkg::ST_FULL;
            end
          end else if (count_r == '0) begin
            stat_r <= aolq_pkg::ST_EMPTY;
          end else begin
            stat_r  <= aolq_pkg::ST_POPPED;
            state_r <= S_POPRD;
          end
        end
        S_POPRD: begin
          state_r <= S_POPWR;
        end
        S_POPWR: begin
          count_r <= last_idx;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= stat_r;
            out_occ_r    <= count_r;
            if (stat_r == aolq_pkg::ST_POPPED) begin
              out_node_r <= b_node32[15:0];
              out_cost_r <= b_cost;
              out_est_r  <= b_est;
              out_from_r <= b_from32[15:0];
            end else begin
              out_node_r <= '0;
              out_cost_r <= '0;
              out_est_r  <= '0;
              out_from_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall      = state_r != S_IDLE;
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_node      = out_node_r;
  assign out_cost      = out_cost_r;
  assign out_estimate  = out_est_r;
  assign out_from      = out_from_r;
  assign out_occupancy = out_occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |->
      (count_r == $past(count_r) + CW'(1) || count_r == $past(count_r) - CW'(1)))
    else $error("Entry count moved by more than one.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_status_r <= aolq_pkg::ST_EMPTY)
    else $error("Result transaction carries an unknown status.");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> !wr_en)
    else $error("Store written during a scan.");
endmodule

// ===== tb/sv/aolq_checker.sv =====
// Checker for the open-list queue unit: watches both channels, predicts each result.
// Depends on aolq_pkg for request and status codes.
module aolq_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_req_type,
  input  logic [15:0] in_node_id,
  input  logic [23:0] in_path_cost,
  input  logic [23:0] in_estimate,
  input  logic [15:0] in_from_node,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [15:0] out_node,
  input  logic [23:0] out_cost,
  input  logic [23:0] out_estimate,
  input  logic [15:0] out_from,
  input  logic [8:0]  out_occupancy,
  output int          fail_count,
  output int          pending,
  output int          pops_seen,
  output int          fulls_seen
);
  typedef struct packed {
    logic [15:0] node;
    logic [23:0] cost;
    logic [23:0] est;
    logic [15:0] from;
  } entry_t;

  typedef struct packed {
    logic [2:0]  status;
    entry_t      ent;
    logic [8:0]  occ;
  } result_t;

  entry_t  open_list[256];
  int      open_count;
  result_t expected_results[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic result_t queue_update(input logic req, input entry_t offer);
    result_t r;
    int slot, best;
    logic [24:0] f, best_f;
    r = '0;
    if (req == aolq_pkg::REQ_OFFER) begin
      slot = -1;
      for (int i = 0; i < open_count; i++)
        if (slot < 0 && open_list[i].node == offer.node) slot = i;
      if (slot >= 0) begin
        if (offer.cost < open_list[slot].cost) begin
          open_list[slot].cost = offer.cost;
          open_list[slot].from = offer.from;
          r.status = aolq_pkg::ST_LOWERED;
        end else begin
          r.status = aolq_pkg::ST_KEPT;
        end
      end else if (open_count >= 256) begin
        r.status = aolq_pkg::ST_FULL;
      end else begin
        open_list[open_count] = offer;
        open_count++;
        r.status = aolq_pkg::ST_INSERTED;
      end
    end else if (open_count == 0) begin
      r.status = aolq_pkg::ST_EMPTY;
    end else begin
      best = 0;
      best_f = open_list[0].cost + open_list[0].est;
      for (int i = 1; i < open_count; i++) begin
        f = open_list[i].cost + open_list[i].est;
        if (f < best_f || (f == best_f && open_list[i].node < open_list[best].node)) begin
          best = i;
          best_f = f;
        end
      end
      r.ent = open_list[best];
      open_count--;
      open_list[best] = open_list[open_count];
      r.status = aolq_pkg::ST_POPPED;
    end
    r.occ = open_count[8:0];
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      open_count = 0;
    end else begin
      if (in_valid && !in_stall) begin
        want = queue_update(in_req_type,
          {in_node_id, in_path_cost, in_estimate, in_from_node});
        if (want.status == aolq_pkg::ST_FULL) fulls_seen++;
        expected_results.insert(expected_results.size(), want);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("unexpected transaction", 32'(out_status), 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (want.status == aolq_pkg::ST_POPPED) pops_seen++;
          if (out_status != want.status)
            report("status", 32'(out_status), 32'(want.status));
          if (out_node != want.ent.node)
            report("node", 32'(out_node), 32'(want.ent.node));
          if (out_cost != want.ent.cost)
            report("cost", 32'(out_cost), 32'(want.ent.cost));
          if (out_estimate != want.ent.est)
            report("estimate", 32'(out_estimate), 32'(want.ent.est));
          if (out_from != want.ent.from)
            report("from", 32'(out_from), 32'(want.ent.from));
          if (out_occupancy != want.occ)
            report("occupancy", 32'(out_occupancy), 32'(want.occ));
        end
      end
    end
    pending = expected_results.size();
  end

  initial begin
    fail_count = 0;
    pending = 0;
    pops_seen = 0;
    fulls_seen = 0;
  end
endmodule

// ===== tb/sv/tb_astar_open_list_queue_unit.sv =====
// Top of the open-list queue testbench: clock, reset, stimulus and verdict.
// Depends on aolq_pkg, aolq_checker and the astar_open_list_queue_unit RTL.
module tb_astar_open_list_queue_unit;
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_req_type = aolq_pkg::REQ_OFFER;
  logic [15:0] in_node_id = '0;
  logic [23:0] in_path_cost = '0;
  logic [23:0] in_estimate = '0;
  logic [15:0] in_from_node = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_node;
  logic [23:0] out_cost;
  logic [23:0] out_estimate;
  logic [15:0] out_from;
  logic [8:0]  out_occupancy;
  int          fail_count, pending, pops_seen, fulls_seen;
  int          sent;
  int          stall_left = 0;
  bit          calm;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  astar_open_list_queue_unit DUT (.*);

  aolq_checker checker_i (.*);

  always @(posedge clk) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= int'($urandom_range(1, 3));
      out_stall  <= 1'b1;
    end
  end

  task automatic send(input logic req, input logic [15:0] node, input logic [23:0] cost,
                      input logic [23:0] est, input logic [15:0] from);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_node_id <= node;
    in_path_cost <= cost;
    in_estimate <= est;
    in_from_node <= from;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic offer(input logic [15:0] node, input logic [23:0] cost);
    send(aolq_pkg::REQ_OFFER, node, cost, 24'($urandom()), 16'($urandom()));
  endtask

  task automatic pop_random();
    send(aolq_pkg::REQ_POP, 16'($urandom()), 24'($urandom()), 24'($urandom()),
         16'($urandom()));
  endtask

  initial begin
    logic [15:0] pool;
    int n;
    sent = 0;
    calm = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send(aolq_pkg::REQ_POP, 16'hffff, 24'hffffff, 24'hffffff, 16'hffff);
    send(aolq_pkg::REQ_OFFER, 16'h0000, 24'h000000, 24'h000000, 16'h0000);
    send(aolq_pkg::REQ_OFFER, 16'hffff, 24'hffffff, 24'hffffff, 16'hffff);
    send(aolq_pkg::REQ_OFFER, 16'h1234, 24'h000100, 24'h000200, 16'h0001);
    send(aolq_pkg::REQ_OFFER, 16'h1233, 24'h000200, 24'h000100, 16'h0002);
    send(aolq_pkg::REQ_OFFER, 16'h1234, 24'h000100, 24'h000000, 16'h0003);
    send(aolq_pkg::REQ_OFFER, 16'h1234, 24'h000080, 24'h000000, 16'h0004);
    send(aolq_pkg::REQ_OFFER, 16'hffff, 24'hfffffe, 24'h000000, 16'h5555);
    send(aolq_pkg::REQ_OFFER, 16'haaaa, 24'haaaaaa, 24'h555555, 16'haaaa);
    repeat (7) pop_random();
    // Fill to capacity, then probe the full behavior.
    for (int i = 0; i < 256; i++) offer(16'h4000 + i[15:0], 24'($urandom_range(0, 4000)));
    offer(16'h7777, 24'd5);
    offer(16'h4005, 24'd0);
    offer(16'h4006, 24'hffffff);
    repeat (256) send(aolq_pkg::REQ_POP, '0, '0, '0, '0);
    send(aolq_pkg::REQ_POP, '0, '0, '0, '0);
    // Random phase: small node pool gives hits, decrease-key and ties.
    n = 0;
    while (n < 1320) begin
      if (n > 1150) calm = 1'b1;
      pool = $urandom_range(0, 9) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 40));
      if ($urandom_range(0, 2) == 0)
        pop_random();
      else if ($urandom_range(0, 3) == 0)
        send(aolq_pkg::REQ_OFFER, pool, 24'($urandom_range(0, 64)),
             24'($urandom_range(0, 64)), 16'($urandom()));
      else
        send(aolq_pkg::REQ_OFFER, pool, 24'($urandom()), 24'($urandom()),
             16'($urandom()));
      n++;
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d transactions: %0d pops returned entries, %0d offers hit a full queue.",
             sent, pops_seen, fulls_seen);
    if (fail_count == 0) $display("[astar_open_list_queue_unit] OK");
    else $display("[astar_open_list_queue_unit] ERROR");
    $finish;
  end

  initial begin
    #50000000;
    $display("[astar_open_list_queue_unit] ERROR");
    $finish;
  end
endmodule

// ===== sim.f =====
design/aolq_pkg.sv
design/aolq_store.sv
design/astar_open_list_queue_unit.sv
tb/sv/aolq_checker.sv
tb/sv/tb_astar_open_list_queue_unit.sv
